/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check clocked on the rising edge, held off while reset is active.
`define CLC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds at every edge, reset included.
`define CLC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/clc_pkg.sv */
// Package with the constants, codes and control structs of the center line picker.
package clc_pkg;

    localparam int MAX_LINES_DEF = 64;
    localparam int DW            = 16;

    localparam logic [2:0] OP_NONE  = 3'd0;
    localparam logic [2:0] OP_SUM   = 3'd1;
    localparam logic [2:0] OP_CLOSE = 3'd2;
    localparam logic [2:0] OP_CAND  = 3'd3;
    localparam logic [2:0] OP_RANK  = 3'd4;
    localparam logic [2:0] OP_FILT  = 3'd5;

    localparam logic [1:0] ST_FOUND = 2'd0;
    localparam logic [1:0] ST_FEW   = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;

    localparam logic [1:0] REG_METHOD = 2'd0;
    localparam logic [1:0] REG_MIN    = 2'd1;
    localparam logic [1:0] REG_MAX    = 2'd2;

    localparam logic [1:0] METHOD_MEAN  = 2'd0;
    localparam logic [1:0] METHOD_RHO   = 2'd1;
    localparam logic [1:0] METHOD_THETA = 2'd2;

    typedef struct packed {
        logic       in_ready;
        logic [2:0] op;
        logic       rd_en;
        logic       ph2;
        logic       clear_acc;
        logic       clear_kept;
        logic       div_start;
        logic       take;
        logic       out_load;
        logic [1:0] out_status;
        logic       clear_set;
    } cmd_t;

    typedef struct packed {
        logic last_acc;
        logic mean;
        logic div_busy;
        logic rank_hit;
        logic out_free;
    } stat_t;

endpackage

/* rtl/core/clc_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module clc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/clc_dp.sv */
// Datapath of the center line picker: line stores, kept stores, accumulators and result.
module clc_dp #(
    parameter int MAX_LINES = clc_pkg::MAX_LINES_DEF,
    parameter int AW        = $clog2(MAX_LINES),
    parameter int CW        = $clog2(MAX_LINES + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  s_tvalid,
    input  logic [31:0]           s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,
    output logic [2:0]            m_tuser,
    input  clc_pkg::cmd_t         cmd,
    input  logic [AW-1:0]         rd_addr,
    input  logic [AW-1:0]         cand_idx,
    output clc_pkg::stat_t        stat,
    output logic [CW-1:0]         line_cnt,
    output logic [CW-1:0]         kept_cnt
);

    localparam int SUMW = clc_pkg::DW + CW;
    localparam int DCW  = $clog2(SUMW + 1);

    logic [1:0]  method_reg;
    logic [15:0] min_reg, max_reg;
    logic [CW-1:0] count_reg, kcount_reg;
    logic        dropped_reg;
    logic        acc, full, wr_main;

    logic [15:0] m_rho_q, m_theta_q, k_rho_q, k_theta_q;
    logic [2:0]  p_op_reg;
    logic        p_valid_reg, p_kept_reg;
    logic [AW-1:0] p_idx_reg, p_cand_reg;
    logic signed [15:0] d_rho;
    logic [15:0] d_theta;

    logic [SUMW-1:0] sum_reg, quot_reg;
    logic [CW-1:0]   rem_reg;
    logic [CW:0]     rem_sh;
    logic [DCW-1:0]  dcnt_reg;

    logic [16:0] best_dist_reg;
    logic signed [15:0] best_rho_reg, cand_rho_reg, l1_rho_reg, l2_rho_reg;
    logic [15:0] best_theta_reg, cand_theta_reg, l1_theta_reg, l2_theta_reg;
    logic [CW-1:0] rank_reg, pass_cnt;

    logic [15:0] ref_theta, adist;
    logic signed [16:0] rdiff;
    logic [16:0] rmag;
    logic        keep, by_theta, k_less, k_le;
    logic        wr_keep;
    logic signed [16:0] rsum;
    logic [16:0] tsum;

    logic        m_valid_reg, m_ovf_reg;
    logic [1:0]  m_status_reg;
    logic [15:0] m_rho_reg, m_theta_reg;

    assign acc     = s_tvalid && cmd.in_ready;
    assign full    = (count_reg == CW'(MAX_LINES));
    assign wr_main = acc && !full;

    clc_ram #(.WIDTH(16), .DEPTH(MAX_LINES)) u_rho_ram (
        .aclk(aclk), .we(wr_main), .waddr(count_reg[AW-1:0]), .wdata(s_tdata[15:0]),
        .raddr(rd_addr), .rdata(m_rho_q)
    );
    clc_ram #(.WIDTH(16), .DEPTH(MAX_LINES)) u_theta_ram (
        .aclk(aclk), .we(wr_main), .waddr(count_reg[AW-1:0]), .wdata(s_tdata[31:16]),
        .raddr(rd_addr), .rdata(m_theta_q)
    );

    assign d_rho   = p_kept_reg ? $signed(k_rho_q) : $signed(m_rho_q);
    assign d_theta = p_kept_reg ? k_theta_q : m_theta_q;

    assign rdiff = 17'(l1_rho_reg) - 17'(d_rho);
    assign rmag  = rdiff[16] ? 17'(-rdiff) : 17'(rdiff);
    assign keep  = ({1'b0, min_reg} <= rmag) && (rmag <= {1'b0, max_reg});
    assign wr_keep = p_valid_reg && (p_op_reg == clc_pkg::OP_FILT) && keep;

    clc_ram #(.WIDTH(16), .DEPTH(MAX_LINES)) u_krho_ram (
        .aclk(aclk), .we(wr_keep), .waddr(kcount_reg[AW-1:0]), .wdata(d_rho),
        .raddr(rd_addr), .rdata(k_rho_q)
    );
    clc_ram #(.WIDTH(16), .DEPTH(MAX_LINES)) u_ktheta_ram (
        .aclk(aclk), .we(wr_keep), .waddr(kcount_reg[AW-1:0]), .wdata(d_theta),
        .raddr(rd_addr), .rdata(k_theta_q)
    );

    assign ref_theta = cmd.ph2 ? l1_theta_reg : quot_reg[15:0];
    assign adist     = (d_theta > ref_theta) ? (d_theta - ref_theta) : (ref_theta - d_theta);
    assign by_theta  = (method_reg != clc_pkg::METHOD_RHO);
    assign k_less    = by_theta ? (d_theta < cand_theta_reg) : (d_rho < cand_rho_reg);
    assign k_le      = by_theta ? (d_theta <= cand_theta_reg) : (d_rho <= cand_rho_reg);
    assign pass_cnt  = cmd.ph2 ? kcount_reg : count_reg;
    assign rem_sh    = {rem_reg, sum_reg[SUMW-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            method_reg  <= clc_pkg::METHOD_MEAN;
            min_reg     <= 16'd16;
            max_reg     <= 16'hFFFF;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            kcount_reg  <= '0;
            p_valid_reg <= 1'b0;
            dcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    clc_pkg::REG_METHOD: method_reg <= cfg_data[1:0];
                    clc_pkg::REG_MIN:    min_reg    <= cfg_data;
                    clc_pkg::REG_MAX:    max_reg    <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.clear_set) begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end else if (acc) begin
                if (full) begin
                    dropped_reg <= 1'b1;
                end else begin
                    count_reg <= count_reg + CW'(1);
                end
            end
            if (cmd.clear_kept) begin
                kcount_reg <= '0;
            end else if (wr_keep) begin
                kcount_reg <= kcount_reg + CW'(1);
            end
            p_valid_reg <= cmd.rd_en;
            if (cmd.div_start) begin
                dcnt_reg <= DCW'(SUMW);
            end else if (dcnt_reg != '0) begin
                dcnt_reg <= dcnt_reg - DCW'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        p_op_reg   <= cmd.op;
        p_kept_reg <= cmd.ph2;
        p_idx_reg  <= rd_addr;
        p_cand_reg <= cand_idx;
        if (cmd.clear_acc) begin
            sum_reg       <= '0;
            best_dist_reg <= 17'h10000;
            rank_reg      <= '0;
        end else if (cmd.div_start) begin
            rem_reg  <= '0;
            quot_reg <= '0;
        end else if (dcnt_reg != '0) begin
            sum_reg <= {sum_reg[SUMW-2:0], 1'b0};
            if (rem_sh >= {1'b0, count_reg}) begin
                rem_reg  <= CW'(rem_sh - {1'b0, count_reg});
                quot_reg <= {quot_reg[SUMW-2:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[CW-1:0];
                quot_reg <= {quot_reg[SUMW-2:0], 1'b0};
            end
        end else if (p_valid_reg) begin
            case (p_op_reg)
                clc_pkg::OP_SUM: sum_reg <= sum_reg + SUMW'(d_theta);
                clc_pkg::OP_CLOSE: begin
                    if ({1'b0, adist} < best_dist_reg) begin
                        best_dist_reg  <= {1'b0, adist};
                        best_rho_reg   <= d_rho;
                        best_theta_reg <= d_theta;
                    end
                end
                clc_pkg::OP_CAND: begin
                    cand_rho_reg   <= d_rho;
                    cand_theta_reg <= d_theta;
                end
                clc_pkg::OP_RANK: begin
                    if (k_less || ((p_idx_reg < p_cand_reg) && k_le)) begin
                        rank_reg <= rank_reg + CW'(1);
                    end
                end
                default: ;
            endcase
        end
        if (cmd.take) begin
            if (cmd.ph2) begin
                l2_rho_reg   <= stat.mean ? best_rho_reg : cand_rho_reg;
                l2_theta_reg <= stat.mean ? best_theta_reg : cand_theta_reg;
            end else begin
                l1_rho_reg   <= stat.mean ? best_rho_reg : cand_rho_reg;
                l1_theta_reg <= stat.mean ? best_theta_reg : cand_theta_reg;
            end
        end
        if (cmd.out_load) begin
            m_status_reg <= cmd.out_status;
            m_ovf_reg    <= dropped_reg;
            if (cmd.out_status == clc_pkg::ST_FOUND) begin
                m_rho_reg   <= rsum[16:1];
                m_theta_reg <= tsum[16:1];
            end else begin
                m_rho_reg   <= '0;
                m_theta_reg <= '0;
            end
        end
    end

    assign rsum = 17'(l1_rho_reg) + 17'(l2_rho_reg);
    assign tsum = {1'b0, l1_theta_reg} + {1'b0, l2_theta_reg};

    assign stat.last_acc = acc && s_tlast;
    assign stat.mean     = (method_reg == clc_pkg::METHOD_MEAN);
    assign stat.div_busy = (dcnt_reg != '0);
    assign stat.rank_hit = (rank_reg == (pass_cnt >> 1));
    assign stat.out_free = !m_valid_reg || m_tready;

    assign line_cnt = count_reg;
    assign kept_cnt = kcount_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_theta_reg, m_rho_reg};
    assign m_tuser  = {m_ovf_reg, m_status_reg};

endmodule

/* rtl/core/clc_ctrl.sv */
// Controller state machine that sequences the scans of the center line picker.
module clc_ctrl #(
    parameter int MAX_LINES = clc_pkg::MAX_LINES_DEF,
    parameter int AW        = $clog2(MAX_LINES),
    parameter int CW        = $clog2(MAX_LINES + 1)
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  clc_pkg::stat_t stat,
    input  logic [CW-1:0]  line_cnt,
    input  logic [CW-1:0]  kept_cnt,
    output clc_pkg::cmd_t  cmd,
    output logic [AW-1:0]  rd_addr,
    output logic [AW-1:0]  cand_idx
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_SUM   = 4'd2;
    localparam logic [3:0] S_DIVGO = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_CLOSE = 4'd5;
    localparam logic [3:0] S_CAND  = 4'd6;
    localparam logic [3:0] S_RANK  = 4'd7;
    localparam logic [3:0] S_RCHK  = 4'd8;
    localparam logic [3:0] S_TAKE  = 4'd9;
    localparam logic [3:0] S_FILT  = 4'd10;
    localparam logic [3:0] S_FCHK  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;
    localparam logic [3:0] S_WAIT  = 4'd13;

    logic [3:0]    state_reg, state_next, ret_reg, ret_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, pass_cnt, cnt_m1;
    logic          ph2_reg, ph2_next;
    logic [1:0]    stat_reg, stat_next;
    logic          j_end, i_end;

    assign pass_cnt = ph2_reg ? kept_cnt : line_cnt;
    assign cnt_m1   = ((state_reg == S_SUM) || (state_reg == S_FILT)) ?
                      (line_cnt - CW'(1)) : (pass_cnt - CW'(1));
    assign j_end    = (j_reg == cnt_m1);
    assign i_end    = (i_reg == pass_cnt - CW'(1));

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        ph2_next   = ph2_reg;
        stat_next  = stat_reg;
        cmd            = '0;
        cmd.ph2        = ph2_reg;
        cmd.op         = clc_pkg::OP_NONE;
        cmd.out_status = stat_reg;
        rd_addr        = j_reg[AW-1:0];
        case (state_reg)
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                if (stat.last_acc) begin
                    state_next = S_START;
                end
            end
            S_START: begin
                ph2_next      = 1'b0;
                cmd.clear_acc = 1'b1;
                i_next        = '0;
                j_next        = '0;
                if (line_cnt < CW'(2)) begin
                    stat_next  = clc_pkg::ST_FEW;
                    state_next = S_OUT;
                end else if (stat.mean) begin
                    state_next = S_SUM;
                end else begin
                    state_next = S_CAND;
                end
            end
            S_SUM: begin
                cmd.rd_en = 1'b1;
                cmd.op    = clc_pkg::OP_SUM;
                j_next    = j_reg + CW'(1);
                if (j_end) begin
                    ret_next   = S_DIVGO;
                    state_next = S_WAIT;
                end
            end
            S_DIVGO: begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV: begin
                if (!stat.div_busy) begin
                    cmd.clear_acc = 1'b1;
                    j_next        = '0;
                    state_next    = S_CLOSE;
                end
            end
            S_CLOSE: begin
                cmd.rd_en = 1'b1;
                cmd.op    = clc_pkg::OP_CLOSE;
                j_next    = j_reg + CW'(1);
                if (j_end) begin
                    ret_next   = S_TAKE;
                    state_next = S_WAIT;
                end
            end
            S_CAND: begin
                rd_addr       = i_reg[AW-1:0];
                cmd.rd_en     = 1'b1;
                cmd.op        = clc_pkg::OP_CAND;
                cmd.clear_acc = 1'b1;
                j_next        = '0;
                state_next    = S_RANK;
            end
            S_RANK: begin
                cmd.rd_en = 1'b1;
                cmd.op    = clc_pkg::OP_RANK;
                j_next    = j_reg + CW'(1);
                if (j_end) begin
                    ret_next   = S_RCHK;
                    state_next = S_WAIT;
                end
            end
            S_RCHK: begin
                if (stat.rank_hit || i_end) begin
                    state_next = S_TAKE;
                end else begin
                    i_next     = i_reg + CW'(1);
                    state_next = S_CAND;
                end
            end
            S_TAKE: begin
                cmd.take = 1'b1;
                if (ph2_reg) begin
                    stat_next  = clc_pkg::ST_FOUND;
                    state_next = S_OUT;
                end else begin
                    cmd.clear_kept = 1'b1;
                    j_next         = '0;
                    state_next     = S_FILT;
                end
            end
            S_FILT: begin
                cmd.rd_en = 1'b1;
                cmd.op    = clc_pkg::OP_FILT;
                j_next    = j_reg + CW'(1);
                if (j_end) begin
                    ret_next   = S_FCHK;
                    state_next = S_WAIT;
                end
            end
            S_FCHK: begin
                i_next = '0;
                j_next = '0;
                if (kept_cnt == '0) begin
                    stat_next  = clc_pkg::ST_NONE;
                    state_next = S_OUT;
                end else begin
                    ph2_next      = 1'b1;
                    cmd.clear_acc = 1'b1;
                    state_next    = stat.mean ? S_CLOSE : S_CAND;
                end
            end
            S_OUT: begin
                if (stat.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.clear_set = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_WAIT: begin
                state_next = ret_reg;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            ph2_reg   <= 1'b0;
            stat_reg  <= clc_pkg::ST_FOUND;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            ph2_reg   <= ph2_next;
            stat_reg  <= stat_next;
        end
    end

    assign cand_idx = i_reg[AW-1:0];

endmodule

/* rtl/core/center_line_from_line_cluster.sv */
// Top level of the center line picker: controller and datapath joined.
//
// Lines are loaded at one per cycle until the line marked by tlast; lines past
// MAX_LINES are dropped and flagged. Evaluation of a set of N lines then walks
// the line memories one entry per cycle: with method 0 it runs a sum pass, a
// bit-serial divide, a closest-angle pass over the N lines, a filter pass, and
// a closest-angle pass over the K kept lines; with a median method a rank search
// finds each median. No item is accepted during evaluation; a finished result
// waits in an output register while the next set loads.
module center_line_from_line_cluster #(
    parameter int MAX_LINES = clc_pkg::MAX_LINES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // rho [15:0], theta [31:16]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // center_rho [15:0], center_theta [31:16]
    output logic [2:0]  m_tuser    // status [1:0], overflow [2]
);

    localparam int AW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);

    clc_pkg::cmd_t  cmd;
    clc_pkg::stat_t stat;
    logic [AW-1:0]  rd_addr, cand_idx;
    logic [CW-1:0]  line_cnt, kept_cnt;

    clc_ctrl #(.MAX_LINES(MAX_LINES), .AW(AW), .CW(CW)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .stat(stat), .line_cnt(line_cnt),
        .kept_cnt(kept_cnt), .cmd(cmd), .rd_addr(rd_addr), .cand_idx(cand_idx)
    );

    clc_dp #(.MAX_LINES(MAX_LINES), .AW(AW), .CW(CW)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cmd(cmd), .rd_addr(rd_addr), .cand_idx(cand_idx), .stat(stat),
        .line_cnt(line_cnt), .kept_cnt(kept_cnt)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = cmd.in_ready;

endmodule

/* rtl/core/clc_checker.sv */
// Port-level checker of the center line picker and its bind statement.
`include "assert_macros.svh"

module clc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    `CLC_ASSERT(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "Stalled result changed.")
    `CLC_ASSERT(a_status, aclk, aresetn, m_tvalid |-> m_tuser[1:0] <= clc_pkg::ST_NONE, "Invalid status code.")
    `CLC_ASSERT(a_zero, aclk, aresetn, m_tvalid && m_tuser[1:0] != clc_pkg::ST_FOUND |-> m_tdata == 32'd0, "Failed result carries a line.")
    `CLC_ASSERT(a_eval, aclk, aresetn, s_tvalid && s_tready && s_tlast |=> !s_tready, "Input taken during evaluation.")
    `CLC_ASSERT_ALWAYS(a_rst, aclk, !aresetn |=> !m_tvalid, "Result valid after reset.")

endmodule

bind center_line_from_line_cluster clc_checker u_clc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tlast(s_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);

/* dv/center_line_from_line_cluster_tb.sv */
// Testbench for the center line picker: directed and random line sets checked against a scoreboard model.
module center_line_from_line_cluster_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_CAP    = 64;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [1:0] REG_SPARE    = 2'd3;
    localparam logic [1:0] METHOD_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] rho;
        logic [15:0] theta;
        logic        overflow;
    } center_t;

    class center_line_scoreboard;
        logic [1:0]         method;
        logic [15:0]        min_dist;
        logic [15:0]        max_dist;
        logic signed [15:0] rho_mem [LINE_CAP];
        logic [15:0]        theta_mem [LINE_CAP];
        int                 count;
        bit                 dropped;
        center_t            expected_centers [$];
        int                 mismatches;

        function new();
            method = clc_pkg::METHOD_MEAN;
            min_dist = 16;
            max_dist = 16'hFFFF;
            count = 0;
            dropped = 0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                clc_pkg::REG_METHOD: method = val[1:0];
                clc_pkg::REG_MIN:    min_dist = val;
                clc_pkg::REG_MAX:    max_dist = val;
                default: ;
            endcase
        endfunction

        function bit key_less(int a, int b, bit by_theta);
            if (by_theta) begin
                return theta_mem[a] < theta_mem[b];
            end
            return rho_mem[a] < rho_mem[b];
        endfunction

        // Entry of rank cnt/2 in a stable order by the key.
        function int median_line(int list [$], bit by_theta);
            int target;
            int rank;
            target = list.size() / 2;
            for (int i = 0; i < list.size(); i++) begin
                rank = 0;
                for (int j = 0; j < list.size(); j++) begin
                    if (key_less(list[j], list[i], by_theta)) begin
                        rank++;
                    end else if (j < i && !key_less(list[i], list[j], by_theta)) begin
                        rank++;
                    end
                end
                if (rank == target) begin
                    return list[i];
                end
            end
            return list[0];
        endfunction

        function int closest_line(int list [$], int target);
            int best;
            int best_dist;
            int d;
            best = list[0];
            best_dist = 65536;
            foreach (list[i]) begin
                d = int'(theta_mem[list[i]]) - target;
                if (d < 0) begin
                    d = -d;
                end
                if (d < best_dist) begin
                    best_dist = d;
                    best = list[i];
                end
            end
            return best;
        endfunction

        function center_t predict_center();
            center_t c;
            int      all_lines [$];
            int      kept [$];
            longint  sum;
            int      l1;
            int      l2;
            int      r1;
            int      d;
            bit      mean_mode;
            bit      by_theta;
            mean_mode = (method == clc_pkg::METHOD_MEAN);
            by_theta = (method != clc_pkg::METHOD_RHO);
            c = '0;
            c.overflow = dropped;
            if (count < 2) begin
                c.status = clc_pkg::ST_FEW;
                return c;
            end
            sum = 0;
            for (int i = 0; i < count; i++) begin
                all_lines = {all_lines, i};
                sum += theta_mem[i];
            end
            if (mean_mode) begin
                l1 = closest_line(all_lines, int'(sum / count));
            end else begin
                l1 = median_line(all_lines, by_theta);
            end
            r1 = int'(rho_mem[l1]);
            for (int i = 0; i < count; i++) begin
                d = r1 - int'(rho_mem[i]);
                if (d < 0) begin
                    d = -d;
                end
                if (d >= int'(min_dist) && d <= int'(max_dist)) begin
                    kept = {kept, i};
                end
            end
            if (kept.size() == 0) begin
                c.status = clc_pkg::ST_NONE;
                return c;
            end
            if (mean_mode) begin
                l2 = closest_line(kept, int'(theta_mem[l1]));
            end else begin
                l2 = median_line(kept, by_theta);
            end
            c.status = clc_pkg::ST_FOUND;
            c.rho = 16'((r1 + int'(rho_mem[l2])) >>> 1);
            c.theta = 16'((int'(theta_mem[l1]) + int'(theta_mem[l2])) >> 1);
            return c;
        endfunction

        function void note_line(logic [15:0] rho, logic [15:0] theta, logic last);
            if (count < LINE_CAP) begin
                rho_mem[count] = rho;
                theta_mem[count] = theta;
                count++;
            end else begin
                dropped = 1;
            end
            if (last) begin
                expected_centers = {expected_centers, predict_center()};
                count = 0;
                dropped = 0;
            end
        endfunction

        function void check_center(logic [31:0] data, logic [2:0] user);
            center_t got;
            center_t want;
            got.status = user[1:0];
            got.overflow = user[2];
            got.rho = data[15:0];
            got.theta = data[31:16];
            if (expected_centers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected result: status %0d rho %0d theta %0d overflow %0d",
                             got.status, $signed(got.rho), got.theta, got.overflow);
                end
                return;
            end
            want = expected_centers.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Mismatch: expected status %0d rho %0d theta %0d overflow %0d,",
                             want.status, $signed(want.rho), want.theta, want.overflow);
                    $display("          actual   status %0d rho %0d theta %0d overflow %0d",
                             got.status, $signed(got.rho), got.theta, got.overflow);
                end
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    center_line_scoreboard sb = new();
    int results_seen = 0;
    int cycles = 0;
    int lines_sent = 0;

    center_line_from_line_cluster uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    initial begin
        aclk = 0;
    end

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("center_line_from_line_cluster test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_center(m_tdata, m_tuser);
            results_seen++;
        end
    end

    // Result side: random stalls, one long hold-off so the input backs up.
    initial begin
        bit held;
        held = 0;
        m_tready = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= 20) begin
                held = 1;
                m_tready = 0;
                repeat (600) @(negedge aclk);
            end else if ($urandom_range(0, 99) == 0) begin
                m_tready = 1;
                repeat ($urandom_range(50, 150)) @(negedge aclk);
            end else if ($urandom_range(0, 49) == 0) begin
                m_tready = 0;
                repeat ($urandom_range(20, 80)) @(negedge aclk);
            end else begin
                m_tready = ($urandom_range(0, 9) < 7);
            end
        end
    end

    task automatic send_line(logic [15:0] rho, logic [15:0] theta, logic last);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        gap = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            s_tvalid = 0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata = {theta, rho};
        s_tlast = last;
        s_tvalid = 1;
        do @(posedge aclk); while (!s_tready);
        sb.note_line(rho, theta, last);
        lines_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic wait_drained();
        s_tvalid = 0;
        while (sb.expected_centers.size() > 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
    endtask

    // One set of lines; clustered sets keep rho and theta within a random spread of a base value.
    task automatic send_set(int n);
        int base_rho;
        int base_theta;
        int spread;
        bit clustered;
        logic [15:0] rho;
        logic [15:0] theta;
        clustered = ($urandom_range(0, 2) != 0);
        base_rho = $urandom_range(0, 65535);
        base_theta = $urandom_range(0, 65535);
        spread = $urandom_range(1, 3000);
        for (int k = 0; k < n; k++) begin
            if (clustered) begin
                rho = 16'(base_rho + $urandom_range(0, spread) - spread / 2);
                theta = 16'(base_theta + $urandom_range(0, spread) - spread / 2);
            end else begin
                rho = 16'($urandom_range(0, 65535));
                theta = 16'($urandom_range(0, 65535));
            end
            send_line(rho, theta, k == n - 1);
        end
    endtask

    initial begin
        logic [1:0]  methods [8] = '{clc_pkg::METHOD_MEAN, clc_pkg::METHOD_RHO,
                                     clc_pkg::METHOD_THETA, METHOD_SPARE,
                                     clc_pkg::METHOD_MEAN, clc_pkg::METHOD_RHO,
                                     clc_pkg::METHOD_THETA, clc_pkg::METHOD_MEAN};
        logic [15:0] mins [8] = '{16'd0, 16'd0, 16'd16, 16'hFFFF, 16'd0, 16'd100, 16'd0, 16'd40};
        logic [15:0] maxs [8] = '{16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd2000,
                                  16'd500, 16'hFFFF};
        int phase_start;
        int r;
        aresetn = 0;
        cfg_valid = 0;
        cfg_index = clc_pkg::REG_METHOD;
        cfg_data = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tlast = 0;
        repeat (9) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // Directed sets under the reset settings.
        send_line(16'h7FFF, 16'hFFFF, 1);
        send_line(16'h8000, 16'h0000, 0);
        send_line(16'h7FFF, 16'hFFFF, 1);
        send_line(16'h0010, 16'h1000, 0);
        send_line(16'h0010, 16'h2000, 0);
        send_line(16'h0010, 16'h3000, 1);
        send_line(16'hFFF0, 16'h4000, 0);
        send_line(16'h0020, 16'h4000, 0);
        send_line(16'h0100, 16'h4000, 0);
        send_line(16'hFF00, 16'h4000, 1);
        send_line(16'h8000, 16'h8000, 0);
        send_line(16'h8001, 16'h7FFF, 1);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            write_reg(clc_pkg::REG_METHOD, 16'(methods[p]));
            write_reg(clc_pkg::REG_MIN, mins[p]);
            write_reg(clc_pkg::REG_MAX, maxs[p]);
            if (p == 3) begin
                write_reg(REG_SPARE, 16'h5A5A);
            end
            phase_start = lines_sent;
            if (p == 1 || p == 4) begin
                send_set(LINE_CAP + 2);
            end
            while (lines_sent - phase_start < 50) begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    send_set(1);
                end else if (r < 88) begin
                    send_set($urandom_range(2, 8));
                end else if (r < 97) begin
                    send_set($urandom_range(9, 20));
                end else begin
                    send_set($urandom_range(60, 70));
                end
            end
            wait_drained();
        end

        repeat (200) @(negedge aclk);
        if (sb.mismatches == 0 && sb.expected_centers.size() == 0) begin
            $display("center_line_from_line_cluster test passed");
        end else begin
            $display("center_line_from_line_cluster test failed");
        end
        $finish;
    end
endmodule
